// ===== rtl/itp_pkg.sv =====
// Package for the shunting-yard infix to postfix converter.
// Holds the stack depth, operator codes, character constants and decode helpers.
// No dependencies.
`timescale 1ns / 1ps

package itp_pkg;

    // Operator stack depth (at least 2) and the width of its fill count.
    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Stored operator code of one stack entry.
    typedef logic [2:0] code_t;

    localparam code_t CODE_LPAREN = 3'd0;
    localparam code_t CODE_PLUS   = 3'd1;
    localparam code_t CODE_MINUS  = 3'd2;
    localparam code_t CODE_MUL    = 3'd3;
    localparam code_t CODE_DIV    = 3'd4;
    localparam code_t CODE_POW    = 3'd5;

    // ASCII characters that the converter recognizes.
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_POW    = 8'h5E;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Input command codes.
    localparam logic CMD_CHAR   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // Per-cycle operation applied to every cell of the stack.
    typedef enum logic [1:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP
    } stack_op_t;

    // Control bundle from the sequencer to the cell row.
    typedef struct packed {
        stack_op_t op;
        code_t     code;
    } stack_ctl_t;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } state_t;

    // Character that an operator code is emitted as.
    function automatic logic [7:0] code_char(input code_t code);
        logic [7:0] ch;
        unique case (code)
            CODE_LPAREN: ch = CH_LPAREN;
            CODE_PLUS:   ch = CH_PLUS;
            CODE_MINUS:  ch = CH_MINUS;
            CODE_MUL:    ch = CH_MUL;
            CODE_DIV:    ch = CH_DIV;
            CODE_POW:    ch = CH_POW;
            default:     ch = CH_NUL;
        endcase
        return ch;
    endfunction

    // Precedence of an operator code; '(' and unused codes rank lowest.
    function automatic logic [1:0] code_prec(input code_t code);
        logic [1:0] p;
        unique case (code)
            CODE_PLUS, CODE_MINUS: p = 2'd1;
            CODE_MUL, CODE_DIV:    p = 2'd2;
            CODE_POW:              p = 2'd3;
            default:               p = 2'd0;
        endcase
        return p;
    endfunction

    // True for the five binary operator characters.
    function automatic logic is_op(input logic [7:0] ch);
        return (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_MUL) ||
               (ch == CH_DIV) || (ch == CH_POW);
    endfunction

    // Code of an operator character; meaningful only when is_op holds.
    function automatic code_t op_code(input logic [7:0] ch);
        code_t c;
        unique case (ch)
            CH_PLUS:  c = CODE_PLUS;
            CH_MINUS: c = CODE_MINUS;
            CH_MUL:   c = CODE_MUL;
            CH_DIV:   c = CODE_DIV;
            default:  c = CODE_POW;
        endcase
        return c;
    endfunction

    // ASCII letters and digits pass straight through.
    function automatic logic is_alnum(input logic [7:0] ch);
        return ((ch >= 8'h30) && (ch <= 8'h39)) ||
               ((ch >= 8'h41) && (ch <= 8'h5A)) ||
               ((ch >= 8'h61) && (ch <= 8'h7A));
    endfunction

endpackage

// ===== rtl/itp_cell.sv =====
// One cell of the operator stack: holds a single code and shifts with its neighbors.
// Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_cell
    import itp_pkg::*;
(
    input  logic      aclk,
    input  stack_op_t op,
    input  code_t     above_code,  // neighbor nearer the top, or the new code at the top
    input  code_t     below_code,  // neighbor farther from the top
    output code_t     code
);

    code_t code_reg;
    code_t code_next;

    // A push moves every entry one place down, a pop one place up.
    always_comb begin
        unique case (op)
            STK_PUSH: code_next = above_code;
            STK_POP:  code_next = below_code;
            default:  code_next = code_reg;
        endcase
    end

    // Payload only; the fill count in the sequencer says which cells are live.
    always_ff @(posedge aclk) begin
        code_reg <= code_next;
    end

    assign code = code_reg;

endmodule

// ===== rtl/itp_ctrl.sv =====
// Sequencer of the converter: takes input beats, decides pops, pushes and emits,
// keeps the stack fill count and the output register. Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_ctrl
    import itp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_cmd,
    input  logic [7:0] s_char,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_char,
    output logic       m_has,
    output logic       m_ovf,
    output logic       m_last,
    output stack_ctl_t stk_ctl,
    input  code_t      top_code,
    input  code_t      sec_code
);

    state_t           state_reg, state_next;
    logic             cmd_reg;
    logic [7:0]       char_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_char_reg, m_char_next;
    logic             m_has_reg, m_has_next;
    logic             m_ovf_reg, m_ovf_next;
    logic             m_last_reg, m_last_next;

    logic             slot_free;
    logic             step_en;
    logic             emit;
    logic [7:0]       emit_char;
    logic             emit_has;
    logic             emit_ovf;
    logic             emit_last;
    logic             done;
    stack_op_t        op;
    code_t            push_code;

    logic             stack_empty;
    logic             stack_full;
    logic             has_two;
    code_t            in_code;
    logic             top_pops;
    logic             sec_pops;

    assign slot_free   = !m_valid_reg || m_tready;
    assign step_en     = (state_reg == ST_WORK) && slot_free;
    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign has_two     = (count_reg > CNT_W'(1));
    assign in_code     = op_code(char_reg);

    // An operator pops an entry that is an operator of greater or equal precedence.
    assign top_pops = (top_code != CODE_LPAREN) &&
                      (code_prec(top_code) >= code_prec(in_code));
    assign sec_pops = (sec_code != CODE_LPAREN) &&
                      (code_prec(sec_code) >= code_prec(in_code));

    // One step of the current item: at most one emitted beat and one stack move.
    always_comb begin
        emit      = 1'b0;
        emit_char = CH_NUL;
        emit_has  = 1'b0;
        emit_ovf  = 1'b0;
        emit_last = 1'b0;
        done      = 1'b1;
        op        = STK_HOLD;
        push_code = CODE_LPAREN;
        if (cmd_reg == CMD_FINISH) begin
            // Flush top first, then a terminator beat.
            if (!stack_empty) begin
                emit      = 1'b1;
                emit_char = code_char(top_code);
                emit_has  = 1'b1;
                op        = STK_POP;
                done      = 1'b0;
            end else begin
                emit      = 1'b1;
                emit_last = 1'b1;
            end
        end else if (is_alnum(char_reg)) begin
            emit      = 1'b1;
            emit_char = char_reg;
            emit_has  = 1'b1;
            emit_last = 1'b1;
        end else if (char_reg == CH_LPAREN) begin
            if (stack_full) begin
                emit      = 1'b1;
                emit_ovf  = 1'b1;
                emit_last = 1'b1;
            end else begin
                op        = STK_PUSH;
                push_code = CODE_LPAREN;
            end
        end else if (char_reg == CH_RPAREN) begin
            // Emit down to the matching '(' and drop it; the last emit is final
            // unless another operator sits under it.
            if (!stack_empty && (top_code != CODE_LPAREN)) begin
                emit      = 1'b1;
                emit_char = code_char(top_code);
                emit_has  = 1'b1;
                emit_last = !(has_two && (sec_code != CODE_LPAREN));
                op        = STK_POP;
                done      = 1'b0;
            end else if (!stack_empty) begin
                op = STK_POP;
            end
        end else if (is_op(char_reg)) begin
            if (!stack_empty && top_pops) begin
                // After a pop the push always finds room, so it adds no beat.
                emit      = 1'b1;
                emit_char = code_char(top_code);
                emit_has  = 1'b1;
                emit_last = !(has_two && sec_pops);
                op        = STK_POP;
                done      = 1'b0;
            end else if (stack_full) begin
                emit      = 1'b1;
                emit_ovf  = 1'b1;
                emit_last = 1'b1;
            end else begin
                op        = STK_PUSH;
                push_code = in_code;
            end
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK: begin
                if (step_en && done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake, stack control, fill count and output register.
    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        stk_ctl.op   = step_en ? op : STK_HOLD;
        stk_ctl.code = push_code;
        count_next   = count_reg;
        if (step_en && (op == STK_PUSH)) begin
            count_next = count_reg + CNT_W'(1);
        end else if (step_en && (op == STK_POP)) begin
            count_next = count_reg - CNT_W'(1);
        end
        m_valid_next = m_valid_reg && !m_tready;
        m_char_next  = m_char_reg;
        m_has_next   = m_has_reg;
        m_ovf_next   = m_ovf_reg;
        m_last_next  = m_last_reg;
        if (step_en && emit) begin
            m_valid_next = 1'b1;
            m_char_next  = emit_char;
            m_has_next   = emit_has;
            m_ovf_next   = emit_ovf;
            m_last_next  = emit_last;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Item and result payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg  <= s_cmd;
            char_reg <= s_char;
        end
        m_char_reg <= m_char_next;
        m_has_reg  <= m_has_next;
        m_ovf_reg  <= m_ovf_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_char   = m_char_reg;
    assign m_has    = m_has_reg;
    assign m_ovf    = m_ovf_reg;
    assign m_last   = m_last_reg;

endmodule

// ===== rtl/infix_to_postfix_converter_top.sv =====
// Top level of the shunting-yard infix to postfix converter.
// Depends on itp_pkg, itp_cell and itp_ctrl.
//
//   Channel  Direction  Beat contents
//   s_       in         tdata[7:0] in_char; tuser[0] command (1 = finish and flush)
//   m_       out        tdata[7:0] out_char; tuser[0] has_char, tuser[1] overflow;
//                       tlast marks the final beat of one input item
//
// An item is accepted in ST_IDLE and then worked in ST_WORK one sequencer step at a
// time: a letter, digit, push, overflow or ignored byte is a single step, an item that
// emits operators pops one per step before its push or drop, and a finish pops each
// entry in turn before its terminator beat. The cell row makes one stack move per cycle
// unless a stalled m_ side holds the current step; a new item is taken only in ST_IDLE.
// Reset clears the fill count, the sequencer and the output valid; no clearing
// pass is needed.
`timescale 1ns / 1ps

module infix_to_postfix_converter_top
    import itp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tuser,   // [0] command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic [1:0] m_tuser,   // [0] has_char, [1] overflow
    output logic       m_tlast
);

    stack_ctl_t stk_ctl;
    code_t      cell_code [STACK_DEPTH];
    logic       m_has;
    logic       m_ovf;

    // Sequencer and output register.
    itp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .s_char   (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_char   (m_tdata),
        .m_has    (m_has),
        .m_ovf    (m_ovf),
        .m_last   (m_tlast),
        .stk_ctl  (stk_ctl),
        .top_code (cell_code[0]),
        .sec_code (cell_code[1])
    );

    // Row of stack cells; cell 0 is the top of the stack.
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        code_t above;
        code_t below;
        if (i == 0) begin : g_first
            assign above = stk_ctl.code;
        end else begin : g_mid
            assign above = cell_code[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_end
            assign below = CODE_LPAREN;
        end else begin : g_inner
            assign below = cell_code[i+1];
        end
        itp_cell u_cell (
            .aclk       (aclk),
            .op         (stk_ctl.op),
            .above_code (above),
            .below_code (below),
            .code       (cell_code[i])
        );
    end

    assign m_tuser = {m_ovf, m_has};

endmodule

// ===== rtl/itp_checker.sv =====
// Port-level checks for the infix to postfix converter, bound to its top level.
// Depends on infix_to_postfix_converter_top.
`timescale 1ns / 1ps

module itp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // A result beat that carries no character always closes its item.
    a_nochar_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("beat without character is not marked last");

    // An emitted character never reports overflow.
    a_char_no_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> !m_tuser[1])
        else $error("character beat flags overflow");

    // Beats without a character carry a zero character field.
    a_nochar_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'h00))
        else $error("beat without character has nonzero data");

    // A stalled result beat holds until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) &&
                                     $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result beat changed");

endmodule

bind infix_to_postfix_converter_top itp_checker u_itp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== sim/infix_to_postfix_converter_top_tb.sv =====
// Self-checking testbench for the shunting-yard infix to postfix converter.
// Drives characters and finish commands, predicts the postfix beats and compares them.
// Depends on itp_pkg and infix_to_postfix_converter_top.
`timescale 1ns / 1ps

module infix_to_postfix_converter_top_tb;
    import itp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 430;

    // One input beat: finish command and character.
    typedef struct {
        logic       cmd;
        logic [7:0] ch;
    } infix_item_t;

    // One output beat, fields in the order the checker reports them.
    typedef struct packed {
        logic [7:0] ch;
        logic       has_ch;
        logic       ovf;
        logic       lst;
    } postfix_beat_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tuser = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    infix_item_t   char_q[$];
    postfix_beat_t postfix_q[$];
    infix_item_t   drv_item;

    // Predicted operator stack, holding the operator characters themselves.
    logic [7:0] op_stack_chars[STACK_DEPTH];
    int         op_depth = 0;

    int  meaningful_items = 0;
    int  items_taken = 0;
    int  mismatches = 0;
    int  cycles = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    bit  s_taken = 0;

    infix_to_postfix_converter_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Idling on both sides is switched off for a window of accepted items.
    function automatic bit calm_window();
        return (items_taken >= 250) && (items_taken < 330);
    endfunction

    function automatic bit is_letter_or_digit(input logic [7:0] ch);
        return (ch inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

    // Operator rank; zero for anything that is not one of the five operators.
    function automatic int rank_of(input logic [7:0] ch);
        case (ch)
            CH_PLUS, CH_MINUS: return 1;
            CH_MUL, CH_DIV:    return 2;
            CH_POW:            return 3;
            default:           return 0;
        endcase
    endfunction

    function automatic bit is_ignored(input logic cmd, input logic [7:0] ch);
        return (cmd == CMD_CHAR) && !is_letter_or_digit(ch) && (ch != CH_LPAREN) &&
               (ch != CH_RPAREN) && (rank_of(ch) == 0);
    endfunction

    // Works out the postfix beats that one accepted item causes.
    task automatic predict_postfix(input logic cmd, input logic [7:0] ch);
        postfix_beat_t beats[$];
        logic [7:0]    top_ch;
        if (cmd == CMD_FINISH) begin
            while (op_depth > 0) begin
                beats.insert(beats.size(),
                             postfix_beat_t'{op_stack_chars[op_depth - 1], 1'b1, 1'b0, 1'b0});
                op_depth--;
            end
            beats.insert(beats.size(), postfix_beat_t'{CH_NUL, 1'b0, 1'b0, 1'b0});
        end else if (is_letter_or_digit(ch)) begin
            beats.insert(beats.size(), postfix_beat_t'{ch, 1'b1, 1'b0, 1'b0});
        end else if (ch == CH_RPAREN) begin
            while (op_depth > 0 && op_stack_chars[op_depth - 1] != CH_LPAREN) begin
                beats.insert(beats.size(),
                             postfix_beat_t'{op_stack_chars[op_depth - 1], 1'b1, 1'b0, 1'b0});
                op_depth--;
            end
            if (op_depth > 0) op_depth--;
        end else if (ch == CH_LPAREN || rank_of(ch) != 0) begin
            // An operator first pops everything of equal or higher rank above the '('.
            if (ch != CH_LPAREN) begin
                while (op_depth > 0) begin
                    top_ch = op_stack_chars[op_depth - 1];
                    if (top_ch == CH_LPAREN || rank_of(top_ch) < rank_of(ch)) break;
                    beats.insert(beats.size(), postfix_beat_t'{top_ch, 1'b1, 1'b0, 1'b0});
                    op_depth--;
                end
            end
            if (op_depth >= STACK_DEPTH) begin
                beats.insert(beats.size(), postfix_beat_t'{CH_NUL, 1'b0, 1'b1, 1'b0});
            end else begin
                op_stack_chars[op_depth] = ch;
                op_depth++;
            end
        end
        if (beats.size() > 0) beats[beats.size() - 1].lst = 1'b1;
        foreach (beats[i]) postfix_q.insert(postfix_q.size(), beats[i]);
    endtask

    // Stimulus helpers.
    task automatic add_item(input logic cmd, input logic [7:0] ch);
        char_q.insert(char_q.size(), infix_item_t'{cmd, ch});
        if (!is_ignored(cmd, ch)) meaningful_items++;
    endtask

    task automatic add_text(input string txt);
        for (int i = 0; i < txt.len(); i++) add_item(CMD_CHAR, txt[i]);
    endtask

    function automatic logic [7:0] random_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10) return 8'(8'h30 + r);
        if (r < 36) return 8'(8'h41 + (r - 10));
        return 8'(8'h61 + (r - 36));
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 4))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_MUL;
            3:       return CH_DIV;
            default: return CH_POW;
        endcase
    endfunction

    // Character of an expression, now and then preceded by a stray byte.
    task automatic add_expr_char(input logic [7:0] ch);
        if ($urandom_range(0, 99) < 5) add_item(CMD_CHAR, 8'($urandom_range(0, 255)));
        add_item(CMD_CHAR, ch);
    endtask

    task automatic gen_operand(input int nest);
        if (nest < 4 && $urandom_range(0, 3) == 0) begin
            add_expr_char(CH_LPAREN);
            gen_expr(nest + 1);
            add_expr_char(CH_RPAREN);
        end else begin
            add_expr_char(random_alnum());
        end
    endtask

    task automatic gen_expr(input int nest);
        int terms;
        terms = $urandom_range(0, 3);
        gen_operand(nest);
        repeat (terms) begin
            add_expr_char(random_operator());
            gen_operand(nest);
        end
    endtask

    // Builds the whole input sequence: directed cases first, then random expressions.
    task automatic build_stimulus();
        int kind;
        int nest;
        // Operator precedence, parentheses, right-hand pops and every operator.
        add_text("a+b*c");
        add_item(CMD_FINISH, 8'h00);
        add_text("(Z-0)^9^z/A");
        add_item(CMD_FINISH, 8'hFF);
        // Unmatched close, ignored bytes at both ends of the range, empty finish.
        add_item(CMD_CHAR, CH_RPAREN);
        add_item(CMD_CHAR, 8'h3A);
        add_item(CMD_CHAR, 8'h00);
        add_item(CMD_CHAR, 8'hFF);
        add_item(CMD_FINISH, 8'h5A);
        add_text("+-");
        add_item(CMD_FINISH, 8'h80);
        // Fill the stack, then overflow with a '(' and with an operator.
        repeat (STACK_DEPTH) add_item(CMD_CHAR, CH_LPAREN);
        add_text("(+q))");
        add_item(CMD_FINISH, 8'h55);

        while (meaningful_items < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                gen_expr(0);
                add_item(CMD_FINISH, 8'($urandom_range(0, 255)));
            end else if (kind < 85) begin
                // Broken expression: a stray parenthesis and maybe no finish.
                gen_expr(1);
                add_item(CMD_CHAR, $urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
                gen_expr(0);
                if ($urandom_range(0, 1)) add_item(CMD_FINISH, 8'($urandom_range(0, 255)));
            end else if (kind < 93) begin
                repeat (5) add_item(CMD_CHAR, 8'($urandom_range(0, 255)));
                add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end else begin
                // Deep nesting around the stack limit.
                nest = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 6);
                repeat (nest) add_item(CMD_CHAR, CH_LPAREN);
                add_item(CMD_CHAR, random_alnum());
                add_item(CMD_CHAR, random_operator());
                add_item(CMD_CHAR, random_alnum());
                if ($urandom_range(0, 1)) repeat (nest) add_item(CMD_CHAR, CH_RPAREN);
                add_item(CMD_FINISH, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Sender: offers the next pending item at the falling edge, idling now and then.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (char_q.size() != 0 && (calm_window() || $urandom_range(0, 99) >= 20)) begin
                drv_item = char_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= drv_item.ch;
                s_tuser  <= drv_item.cmd;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off that backs up the input side.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (!hold_done && items_taken >= 120) begin
                hold_left = 400;
                hold_done = 1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm_window() || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // Monitor: predicts on every accepted input beat and checks every output beat.
    always @(posedge aclk) begin
        postfix_beat_t want;
        postfix_beat_t got;
        s_taken = aresetn && s_tvalid && s_tready;
        if (s_taken) begin
            predict_postfix(s_tuser, s_tdata);
            items_taken++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata, m_tuser[0], m_tuser[1], m_tlast};
            if (postfix_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected beat: char %h has_char %b overflow %b last %b",
                             got.ch, got.has_ch, got.ovf, got.lst);
            end else begin
                want = postfix_q.pop_front();
                if (got.ch !== want.ch || got.has_ch !== want.has_ch ||
                    got.ovf !== want.ovf || got.lst !== want.lst) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected char %h has_char %b overflow %b ",
                                  "last %b, got char %h has_char %b overflow %b last %b"},
                                 want.ch, want.has_ch, want.ovf, want.lst,
                                 got.ch, got.has_ch, got.ovf, got.lst);
                end
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Reset, stimulus and end of run.
    initial begin
        build_stimulus();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        while (char_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (postfix_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && postfix_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
